// ===== rtl/gcov_pkg.sv =====
package gcov_pkg;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned NUM_CH    = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PROD_W    = 2 * CH_W;

  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [PROD_W-1:0] prod_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEXT_RED   = 2'd0,
    REG_TEXT_GREEN = 2'd1,
    REG_TEXT_BLUE  = 2'd2
  } reg_idx_t;

  // After the alpha and destination weight products.
  typedef struct packed {
    chan_t                  an;
    chan_t                  w;
    chan_t                  m;
    logic [NUM_CH-1:0][CH_W-1:0] dc;
  } s1_t;

  // After the per-channel products.
  typedef struct packed {
    chan_t                         an;
    logic [NUM_CH-1:0][PROD_W-1:0] dw;
    logic [NUM_CH-1:0][PROD_W-1:0] sm;
  } s2_t;

  // Division in flight: work holds {remainder, dividend bits / quotient bits}.
  typedef struct packed {
    chan_t                         an;
    logic [NUM_CH-1:0]             sat;
    logic [NUM_CH-1:0][PROD_W-1:0] work;
  } div_t;

  typedef struct packed {
    chan_t                       an;
    logic [NUM_CH-1:0][CH_W-1:0] c;
  } out_t;

  // One restoring division step. The remainder in the upper byte stays below
  // the divisor, so the shifted trial value fits in nine bits.
  function automatic prod_t div_step(prod_t work, chan_t an);
    logic [CH_W:0] t;
    logic [CH_W:0] d;
    t = work[PROD_W-1:CH_W-1];
    d = t - {1'b0, an};
    if (t >= {1'b0, an}) begin
      return {d[CH_W-1:0], work[CH_W-2:0], 1'b1};
    end else begin
      return {t[CH_W-1:0], work[CH_W-2:0], 1'b0};
    end
  endfunction

endpackage

// ===== rtl/gcov_pix_in_if.sv =====
interface gcov_pix_in_if import gcov_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t dest_alpha;
  chan_t dest_red;
  chan_t dest_green;
  chan_t dest_blue;
  chan_t coverage;

  modport source (output valid, dest_alpha, dest_red, dest_green, dest_blue, coverage,
                  input ready);
  modport sink   (input valid, dest_alpha, dest_red, dest_green, dest_blue, coverage,
                  output ready);
endinterface

// ===== rtl/gcov_pix_out_if.sv =====
interface gcov_pix_out_if import gcov_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t new_alpha;
  chan_t new_red;
  chan_t new_green;
  chan_t new_blue;

  modport source (output valid, new_alpha, new_red, new_green, new_blue, input ready);
  modport sink   (input valid, new_alpha, new_red, new_green, new_blue, output ready);
endinterface

// ===== rtl/gcov_cfg_if.sv =====
interface gcov_cfg_if import gcov_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  chan_t                data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/glyph_coverage_over_composite_core.sv =====
// Glyph coverage over composite.
// Blends the solid text color, weighted by the glyph coverage byte, over one
// unpremultiplied ARGB destination pixel per beat.
// Channels: pix_in carries the destination pixel and coverage, pix_out the
// blended pixel, both valid/ready. cfg writes the text color registers
// (index 0 red, 1 green, 2 blue; other indexes are ignored) and is always
// ready; write it only while no pixel is in flight.
// Throughput is one pixel per clock while the receiver takes results: two
// multiply stages, one add and overflow compare stage, then four stages of
// a pipelined restoring divider that retire two quotient bits each.
// Each stage holds its data while the stage ahead is full, so when the
// receiver stalls the pipeline fills up and pix_in.ready drops only once
// every stage holds a pixel; nothing is dropped or repeated.
// Reset (rst, synchronous) empties the pipeline and clears the text color.
module glyph_coverage_over_composite_core import gcov_pkg::*; (
  input logic            clk,
  input logic            rst,
  gcov_pix_in_if.sink    pix_in,
  gcov_pix_out_if.source pix_out,
  gcov_cfg_if.sink       cfg
);

  localparam int unsigned NSTG = 7;

  chan_t [NUM_CH-1:0] color;

  logic [NSTG:1]   vld;
  logic [NSTG+1:1] ld;

  s1_t  st1, st1_next;
  s2_t  st2, st2_next;
  div_t st3, st3_next;
  div_t st4, st4_next;
  div_t st5, st5_next;
  div_t st6, st6_next;
  out_t st7, st7_next;

  // Configuration.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TEXT_RED:   color[0] <= cfg.data;
        REG_TEXT_GREEN: color[1] <= cfg.data;
        REG_TEXT_BLUE:  color[2] <= cfg.data;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or its content moves on.
  always_comb begin
    ld[NSTG+1] = pix_out.ready;
    for (int i = NSTG; i >= 1; i--) begin
      ld[i] = !vld[i] || ld[i+1];
    end
  end

  assign pix_in.ready = ld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[1]) begin
        vld[1] <= pix_in.valid;
      end
      for (int i = 2; i <= NSTG; i++) begin
        if (ld[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 1: combined alpha and destination weight.
  always_comb begin
    chan_t inv_m;
    prod_t pa;
    prod_t pw;
    inv_m = ~pix_in.coverage;
    pa = {{CH_W{1'b0}}, ~pix_in.dest_alpha} * {{CH_W{1'b0}}, inv_m};
    pw = {{CH_W{1'b0}}, pix_in.dest_alpha} * {{CH_W{1'b0}}, inv_m};
    st1_next.an    = ~pa[PROD_W-1:CH_W];
    st1_next.w     = pw[PROD_W-1:CH_W];
    st1_next.m     = pix_in.coverage;
    st1_next.dc[0] = pix_in.dest_red;
    st1_next.dc[1] = pix_in.dest_green;
    st1_next.dc[2] = pix_in.dest_blue;
  end

  // Stage 2: destination and source terms of each channel.
  always_comb begin
    st2_next.an = st1.an;
    for (int c = 0; c < NUM_CH; c++) begin
      st2_next.dw[c] = {{CH_W{1'b0}}, st1.dc[c]} * {{CH_W{1'b0}}, st1.w};
      st2_next.sm[c] = {{CH_W{1'b0}}, color[c]} * {{CH_W{1'b0}}, st1.m};
    end
  end

  // Stage 3: numerator and overflow test. The quotient exceeds a byte exactly
  // when the numerator's upper nine bits reach the divisor.
  always_comb begin
    logic [PROD_W:0] num;
    st3_next.an = st2.an;
    for (int c = 0; c < NUM_CH; c++) begin
      num = {1'b0, st2.dw[c]} + {1'b0, st2.sm[c]};
      st3_next.sat[c]  = num[PROD_W:CH_W] >= {1'b0, st2.an};
      st3_next.work[c] = num[PROD_W-1:0];
    end
  end

  // Stages 4 to 6: two quotient bits each.
  always_comb begin
    st4_next = st3;
    st5_next = st4;
    st6_next = st5;
    for (int c = 0; c < NUM_CH; c++) begin
      st4_next.work[c] = div_step(div_step(st3.work[c], st3.an), st3.an);
      st5_next.work[c] = div_step(div_step(st4.work[c], st4.an), st4.an);
      st6_next.work[c] = div_step(div_step(st5.work[c], st5.an), st5.an);
    end
  end

  // Stage 7: last two quotient bits and saturation.
  always_comb begin
    prod_t q;
    st7_next.an = st6.an;
    for (int c = 0; c < NUM_CH; c++) begin
      q = div_step(div_step(st6.work[c], st6.an), st6.an);
      st7_next.c[c] = st6.sat[c] ? {CH_W{1'b1}} : q[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) st1 <= st1_next;
    if (ld[2]) st2 <= st2_next;
    if (ld[3]) st3 <= st3_next;
    if (ld[4]) st4 <= st4_next;
    if (ld[5]) st5 <= st5_next;
    if (ld[6]) st6 <= st6_next;
    if (ld[7]) st7 <= st7_next;
  end

  assign pix_out.valid     = vld[NSTG];
  assign pix_out.new_alpha = st7.an;
  assign pix_out.new_red   = st7.c[0];
  assign pix_out.new_green = st7.c[1];
  assign pix_out.new_blue  = st7.c[2];

  // The combined alpha can never be zero.
  a_alpha_nonzero: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid |-> pix_out.new_alpha != '0)
    else $error("combined alpha is zero");

  // An accepted pixel always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (pix_in.valid && pix_in.ready) |=> vld[1])
    else $error("accepted pixel lost at pipeline entry");

  // Input backpressure only when every stage is occupied.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> &vld)
    else $error("input stalled with a free stage");

  // Division invariant: an unsaturated remainder stays below the divisor.
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    (vld[6] && !st6.sat[0]) |-> st6.work[0][PROD_W-1:CH_W] < st6.an)
    else $error("divider remainder out of range");

endmodule

// ===== tb/glyph_coverage_over_composite_core_tb.sv =====
module glyph_coverage_over_composite_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gcov_pkg::*;

  localparam int unsigned PIPE_LATENCY = 7;
  localparam int unsigned NUM_PHASES   = 7;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned MAX_IDLE     = 15;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned NUM_DIR_ROWS = 23;
  localparam int unsigned TIMEOUT_NS   = 10_000_000;

  // The index that maps to no color register; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

  typedef struct packed {
    chan_t da;
    chan_t dr;
    chan_t dg;
    chan_t db;
    chan_t cov;
  } dst_px_t;

  typedef struct packed {
    chan_t alpha;
    chan_t red;
    chan_t green;
    chan_t blue;
  } blend_px_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    chan_t                data;
    chan_t                da;
    chan_t                dr;
    chan_t                dg;
    chan_t                db;
    chan_t                cov;
    logic                 chk;
    chan_t                ea;
    chan_t                er;
    chan_t                eg;
    chan_t                eb;
  } stim_row_t;

  // Rows with chk set carry a result that follows directly from the formula:
  // no coverage over a clear pixel gives alpha 1, full coverage gives the text
  // color, and the reset text color is black.
  stim_row_t dir_rows [NUM_DIR_ROWS] = '{
    '{ROW_PIX, 0, 0,   0,   0,   0,   0,   0, 1,   1,   0,   0,   0},
    '{ROW_PIX, 0, 0,   0, 255, 255, 255,   0, 1,   1,   0,   0,   0},
    '{ROW_PIX, 0, 0, 255,   0,   0,   0,   0, 1, 255,   0,   0,   0},
    '{ROW_PIX, 0, 0, 255, 255, 255, 255, 255, 1, 255,   0,   0,   0},
    '{ROW_PIX, 0, 0, 255, 255, 255, 255,   0, 0,   0,   0,   0,   0},
    '{ROW_CFG, REG_TEXT_RED,   255, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, REG_TEXT_GREEN, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, REG_TEXT_BLUE,  255, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_PIX, 0, 0,   0,   0,   0,   0, 255, 1, 255, 255, 255, 255},
    '{ROW_PIX, 0, 0, 255,   0,   0,   0, 255, 1, 255, 255, 255, 255},
    '{ROW_PIX, 0, 0,   0,   0,   0,   0,   1, 0,   0,   0,   0,   0},
    '{ROW_PIX, 0, 0,   1, 255,   0, 255, 254, 0,   0,   0,   0,   0},
    '{ROW_PIX, 0, 0, 254,   0, 255,   0,   1, 0,   0,   0,   0,   0},
    '{ROW_CFG, REG_TEXT_GREEN,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, REG_TEXT_BLUE,  128, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, REG_UNMAPPED,     0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_PIX, 0, 0,   0,   0,   0,   0, 255, 1, 255, 255,   0, 128},
    '{ROW_PIX, 0, 0, 128, 255,   0, 255, 128, 0,   0,   0,   0,   0},
    '{ROW_PIX, 0, 0, 255, 255,   0,   0,   1, 0,   0,   0,   0,   0},
    '{ROW_PIX, 0, 0, 255,   0, 255,   0, 254, 0,   0,   0,   0,   0},
    '{ROW_PIX, 0, 0, 255,   0,   0, 255, 127, 0,   0,   0,   0,   0},
    '{ROW_PIX, 0, 0, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 0, 0, 0, 0, 0},
    '{ROW_PIX, 0, 0, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 0, 0, 0, 0, 0}
  };

  logic clk;
  logic rst;
  logic sink_ready;
  int unsigned stall_left;

  bit src_gaps;
  bit sink_stalls;

  chan_t     text_color [NUM_CH];
  blend_px_t expected_px_q [$];

  int unsigned mismatches;
  int unsigned beats_checked;
  int unsigned pixels_sent;
  int unsigned cfg_writes;

  gcov_pix_in_if  pix_in ();
  gcov_pix_out_if pix_out ();
  gcov_cfg_if     cfg ();

  assign pix_out.ready = sink_ready;

  glyph_coverage_over_composite_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out),
    .cfg     (cfg)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("timeout: %0d results still outstanding", expected_px_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Over operator with coverage as source alpha, each channel on its own.
  function automatic blend_px_t blend_over(dst_px_t px);
    int unsigned da;
    int unsigned m;
    int unsigned inv_m;
    int unsigned an;
    int unsigned w;
    int unsigned num;
    int unsigned q;
    chan_t       dc [NUM_CH];
    chan_t       ch [NUM_CH];
    blend_px_t   res;
    da    = px.da;
    m     = px.cov;
    inv_m = 255 ^ m;
    an    = 255 ^ ((((255 ^ da) * inv_m) >> 8) & 255);
    w     = (inv_m * da) >> 8;
    dc    = '{px.dr, px.dg, px.db};
    for (int c = 0; c < NUM_CH; c++) begin
      num = dc[c] * w + text_color[c] * m;
      q   = (an == 0) ? 0 : num / an;
      ch[c] = (q > 255) ? 8'd255 : q[CH_W-1:0];
    end
    res.alpha = an[CH_W-1:0];
    res.red   = ch[0];
    res.green = ch[1];
    res.blue  = ch[2];
    return res;
  endfunction

  // Biased toward the byte extremes so the corners of the formula come up often.
  function automatic chan_t rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return $urandom_range(0, 1) ? 8'd1 : 8'd254;
      default: return chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic write_color_reg(logic [CFG_IDX_W-1:0] idx, chan_t data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!(cfg.valid && cfg.ready));
    if (idx < NUM_CH) text_color[idx] = data;
    cfg_writes++;
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(dst_px_t px, logic chk, blend_px_t fixed);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in.valid      <= 1'b1;
    pix_in.dest_alpha <= px.da;
    pix_in.dest_red   <= px.dr;
    pix_in.dest_green <= px.dg;
    pix_in.dest_blue  <= px.db;
    pix_in.coverage   <= px.cov;
    do @(posedge clk); while (!(pix_in.valid && pix_in.ready));
    expected_px_q.push_back(chk ? fixed : blend_over(px));
    pixels_sent++;
  endtask

  // Stops sending and waits until every blended pixel has come back.
  task automatic drain_pipe();
    pix_in.valid <= 1'b0;
    do @(posedge clk); while (expected_px_q.size() != 0);
  endtask

  always @(posedge clk) begin : sink_side
    blend_px_t   got;
    blend_px_t   want;
    int unsigned stall;
    if (rst) begin
      sink_ready <= 1'b0;
      stall_left <= 0;
    end else if (pix_out.valid && pix_out.ready) begin
      got = '{pix_out.new_alpha, pix_out.new_red, pix_out.new_green, pix_out.new_blue};
      if (expected_px_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result beat: a=%0d r=%0d g=%0d b=%0d",
                   got.alpha, got.red, got.green, got.blue);
      end else begin
        want = expected_px_q.pop_front();
        if (got.alpha !== want.alpha || got.red !== want.red ||
            got.green !== want.green || got.blue !== want.blue) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("beat %0d: expected a=%0d r=%0d g=%0d b=%0d, got a=%0d r=%0d g=%0d b=%0d",
                     beats_checked, want.alpha, want.red, want.green, want.blue,
                     got.alpha, got.red, got.green, got.blue);
        end
      end
      beats_checked++;
      stall = sink_stalls ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall == 0) begin
        sink_ready <= 1'b1;
      end else begin
        sink_ready <= 1'b0;
        stall_left <= stall;
      end
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      sink_ready <= (stall_left == 1);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  initial begin : stimulus
    stim_row_t r;
    dst_px_t   px;
    blend_px_t fixed;
    chan_t     phase_color [NUM_CH];

    rst               = 1'b1;
    pix_in.valid      = 1'b0;
    pix_in.dest_alpha = '0;
    pix_in.dest_red   = '0;
    pix_in.dest_green = '0;
    pix_in.dest_blue  = '0;
    pix_in.coverage   = '0;
    cfg.valid         = 1'b0;
    cfg.index         = REG_TEXT_RED;
    cfg.data          = '0;
    text_color        = '{default: '0};
    src_gaps          = 1'b1;
    sink_stalls       = 1'b1;
    mismatches        = 0;
    beats_checked     = 0;
    pixels_sent       = 0;
    cfg_writes        = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.kind == ROW_CFG) begin
        drain_pipe();
        write_color_reg(r.idx, r.data);
      end else begin
        px    = '{r.da, r.dr, r.dg, r.db, r.cov};
        fixed = '{r.ea, r.er, r.eg, r.eb};
        send_pixel(px, r.chk, fixed);
      end
    end

    // Each phase picks a text color, then streams random pixels; some phases
    // run with no gaps on one or both sides so the pipeline also sees
    // full-rate traffic.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_pipe();
      src_gaps    = (p % 3 != 1);
      sink_stalls = (p % 4 != 0);
      for (int c = 0; c < NUM_CH; c++)
        phase_color[c] = (p == 0) ? 8'd0 : (p == 1) ? 8'd255 : rand_byte();
      write_color_reg(REG_TEXT_BLUE, phase_color[2]);
      write_color_reg(REG_TEXT_RED, phase_color[0]);
      if ($urandom_range(0, 1)) write_color_reg(REG_UNMAPPED, rand_byte());
      write_color_reg(REG_TEXT_GREEN, phase_color[1]);
      repeat (PHASE_ITEMS) begin
        px = '{rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte()};
        send_pixel(px, 1'b0, '0);
      end
    end

    drain_pipe();
    repeat (2 * PIPE_LATENCY) @(posedge clk);

    $display("Blended %0d pixels under %0d register writes across %0d random color phases.",
             pixels_sent, cfg_writes, NUM_PHASES);
    $display("Compared %0d result beats, %0d mismatches.", beats_checked, mismatches);
    if (mismatches == 0 && expected_px_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
